### design/rbm_pkg.sv
// Shared types and constants for the RGB box mean filter.
// No dependencies; every design file but rbm_ram refers to it by scoped names.
`timescale 1ns / 1ps

package rbm_pkg;

  localparam int CH_W       = 8;
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int MAX_HEIGHT = 4096;

  localparam logic [FW_W-1:0] FRAME_WIDTH_RESET  = 12'd640;
  localparam logic [FH_W-1:0] FRAME_HEIGHT_RESET = 13'd480;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic            kind;
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
    logic            frame_end;
  } result_t;

  // Per-beat decisions made by the position sequencer.
  typedef struct packed {
    logic write_en;   // position lies inside the frame
    logic first_row;  // input row 0: no earlier column sum
    logic early_row;  // input row below the window span: nothing leaves
    logic produce;    // this beat yields a result
    logic filter;     // result is a window mean, not a pass-through
    logic last;       // result is the final one of the frame
  } step_flags_t;

endpackage

### design/rbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rbm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/rbm_seq.sv
// Position sequencer: frame size registers, input and output raster counters.
// Depends on rbm_pkg.
`timescale 1ns / 1ps

module rbm_seq #(
  parameter int RADIUS    = 5,
  parameter int MAX_WIDTH = 2048
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  rbm_pkg::cfg_reg_t                cfg_index,
  input  logic [rbm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                             step,
  output logic [$clog2(MAX_WIDTH)-1:0]     col,
  output logic [$clog2(2*RADIUS+1)-1:0]    slot,
  output logic [$clog2(MAX_WIDTH)-1:0]     ocol,
  output logic [$clog2(2*RADIUS+1)-1:0]    oslot,
  output rbm_pkg::step_flags_t             flags
);

  localparam int SPAN   = 2 * RADIUS + 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int EW     = $clog2(MAX_WIDTH + 1);
  localparam int SLOT_W = $clog2(SPAN);
  localparam int ROW_W  = rbm_pkg::FH_W + 1;
  localparam int LAG_W  = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);

  function automatic logic [EW-1:0] clamp_w(input logic [rbm_pkg::FW_W-1:0] v);
    logic [EW-1:0] r;
    if (v == '0) begin
      r = EW'(1);
    end else if (int'(v) > MAX_WIDTH) begin
      r = EW'(MAX_WIDTH);
    end else begin
      r = EW'(v);
    end
    return r;
  endfunction

  function automatic logic [rbm_pkg::FH_W-1:0] clamp_h(input logic [rbm_pkg::FH_W-1:0] v);
    logic [rbm_pkg::FH_W-1:0] r;
    if (v == '0) begin
      r = rbm_pkg::FH_W'(1);
    end else if (int'(v) > rbm_pkg::MAX_HEIGHT) begin
      r = rbm_pkg::FH_W'(rbm_pkg::MAX_HEIGHT);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [EW-1:0]            eff_w;
  logic [rbm_pkg::FH_W-1:0] eff_h;
  logic [ROW_W-1:0]         row;
  logic [LAG_W-1:0]         lead;
  logic [rbm_pkg::FH_W-1:0] orow;
  logic [LAG_W-1:0]         lag;
  logic                     col_end;
  logic                     ocol_end;

  assign lag      = LAG_W'(RADIUS) * LAG_W'(eff_w) + LAG_W'(RADIUS);
  assign col_end  = (EW'(col) + EW'(1)) == eff_w;
  assign ocol_end = (EW'(ocol) + EW'(1)) == eff_w;

  always_comb begin
    flags.write_en  = row < ROW_W'(eff_h);
    flags.first_row = row == '0;
    flags.early_row = row < ROW_W'(SPAN);
    flags.produce   = lead == lag;
    flags.filter    = (orow >= rbm_pkg::FH_W'(RADIUS)) && (ocol >= COL_W'(RADIUS))
                      && ((eff_w - EW'(ocol)) > EW'(RADIUS))
                      && ((eff_h - orow) > rbm_pkg::FH_W'(RADIUS));
    flags.last      = (orow == eff_h - rbm_pkg::FH_W'(1)) && ocol_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= clamp_w(rbm_pkg::FRAME_WIDTH_RESET);
      eff_h <= clamp_h(rbm_pkg::FRAME_HEIGHT_RESET);
      row   <= '0;
      col   <= '0;
      slot  <= '0;
      lead  <= '0;
      orow  <= '0;
      ocol  <= '0;
      oslot <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbm_pkg::REG_FRAME_WIDTH:  eff_w <= clamp_w(cfg_data[rbm_pkg::FW_W-1:0]);
        rbm_pkg::REG_FRAME_HEIGHT: eff_h <= clamp_h(cfg_data[rbm_pkg::FH_W-1:0]);
      endcase
      row   <= '0;
      col   <= '0;
      slot  <= '0;
      lead  <= '0;
      orow  <= '0;
      ocol  <= '0;
      oslot <= '0;
    end else if (step) begin
      if (flags.produce && flags.last) begin
        row   <= '0;
        col   <= '0;
        slot  <= '0;
        lead  <= '0;
        orow  <= '0;
        ocol  <= '0;
        oslot <= '0;
      end else begin
        if (col_end) begin
          col  <= '0;
          row  <= row + ROW_W'(1);
          slot <= (slot == SLOT_W'(SPAN - 1)) ? '0 : slot + SLOT_W'(1);
        end else begin
          col <= col + COL_W'(1);
        end
        if (!flags.produce) begin
          lead <= lead + LAG_W'(1);
        end else if (ocol_end) begin
          ocol  <= '0;
          orow  <= orow + rbm_pkg::FH_W'(1);
          oslot <= (oslot == SLOT_W'(SPAN - 1)) ? '0 : oslot + SLOT_W'(1);
        end else begin
          ocol <= ocol + COL_W'(1);
        end
      end
    end
  end

endmodule

### design/rbm_accum.sv
// Column sum update and running window sum over the last span of columns.
// Depends on rbm_pkg.
`timescale 1ns / 1ps

module rbm_accum #(
  parameter int RADIUS = 5
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        shift,
  input  rbm_pkg::step_flags_t                        flags,
  input  logic [3*rbm_pkg::CH_W-1:0]                  pix,
  input  logic [3*rbm_pkg::CH_W-1:0]                  old_pix,
  input  logic [3*$clog2((2*RADIUS+1)*255+1)-1:0]     cs_mem,
  input  logic                                        fwd,
  input  logic [3*$clog2((2*RADIUS+1)*255+1)-1:0]     fwd_data,
  output logic [3*$clog2((2*RADIUS+1)*255+1)-1:0]     cs_new,
  output logic [3*$clog2((2*RADIUS+1)*(2*RADIUS+1)*255+1)-1:0] win_sum
);

  localparam int SPAN = 2 * RADIUS + 1;
  localparam int CS_W = $clog2(SPAN * 255 + 1);
  localparam int WS_W = $clog2(SPAN * SPAN * 255 + 1);
  localparam int CH_W = rbm_pkg::CH_W;

  logic [3*CS_W-1:0] taps [SPAN];
  logic [3*CS_W-1:0] cs_src;

  // a write still in flight to the same column wins over the RAM word
  assign cs_src = fwd ? fwd_data : cs_mem;

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [CS_W-1:0] prev;
    logic [CS_W-1:0] leaving;
    logic [WS_W-1:0] acc;
    assign prev    = flags.first_row ? '0 : cs_src[CS_W*ch +: CS_W];
    assign leaving = flags.early_row ? '0 : CS_W'(old_pix[CH_W*ch +: CH_W]);
    assign cs_new[CS_W*ch +: CS_W] = prev + CS_W'(pix[CH_W*ch +: CH_W]) - leaving;

    always_ff @(posedge clk) begin
      if (rst) begin
        acc <= '0;
      end else if (shift) begin
        acc <= acc + WS_W'(cs_new[CS_W*ch +: CS_W])
                   - WS_W'(taps[SPAN-1][CS_W*ch +: CS_W]);
      end
    end

    assign win_sum[WS_W*ch +: WS_W] = acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SPAN; i++) begin
        taps[i] <= '0;
      end
    end else if (shift) begin
      taps[0] <= cs_new;
      for (int i = 1; i < SPAN; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

endmodule

### design/rbm_mean.sv
// Window sum to mean: division by the window area as a reciprocal multiply.
// Depends on rbm_pkg.
`timescale 1ns / 1ps

module rbm_mean #(
  parameter int RADIUS = 5
) (
  input  logic [$clog2((2*RADIUS+1)*(2*RADIUS+1)*255+1)-1:0] sum,
  output logic [rbm_pkg::CH_W-1:0]                           mean
);

  localparam int AREA = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int K    = $clog2(AREA * AREA * 255) + 1;
  localparam int M    = ((1 << K) + AREA - 1) / AREA;
  localparam int PW   = K + rbm_pkg::CH_W;

  logic [PW-1:0] prod;

  // rounded-up reciprocal with 2^K above area * max sum: exact for all sums
  assign prod = PW'(sum) * PW'(M);
  assign mean = prod[PW-1:K];

endmodule

### design/rgb_box_mean_filter_core.sv
// Top level of the RGB box mean filter: pipeline, line store and column sums.
// Depends on rbm_pkg, rbm_ram, rbm_seq, rbm_accum, rbm_mean.
//
// Usage:
//   pixel / pixel_valid / pixel_stall carry raster-order RGB beats; kind = 1
//   marks a flush beat, taken as a black pixel. result / result_valid
//   / result_stall carry the output; frame_end flags the frame's last beat.
//   Each result is the mean over a (2*RADIUS+1)^2 window, or the pixel
//   itself near an edge. Results trail inputs by RADIUS rows plus RADIUS
//   pixels, so RADIUS*width+RADIUS flush beats drain the frame tail.
//   write_enable / write_index / write_data set frame width and height and
//   restart the frame; write only while idle.
//   Throughput: one beat per clock while the output is not stalled; the
//   column sum RAM is read and written each beat on separate ports. Each
//   result passes the stage one, stage two and output registers.
//   When result_stall holds a waiting result, the whole pipeline freezes
//   and pixel_stall rises. Synchronous reset empties the pipeline and
//   restores 640 x 480; RAM contents are not cleared.
`timescale 1ns / 1ps

module rgb_box_mean_filter_core #(
  parameter int RADIUS    = 5,
  parameter int MAX_WIDTH = 2048
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rbm_pkg::pixel_t                pixel,
  input  logic                           pixel_valid,
  output logic                           pixel_stall,
  output rbm_pkg::result_t               result,
  output logic                           result_valid,
  input  logic                           result_stall,
  input  logic                           write_enable,
  input  rbm_pkg::cfg_reg_t              write_index,
  input  logic [rbm_pkg::CFG_DATA_W-1:0] write_data
);

  localparam int SPAN   = 2 * RADIUS + 1;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int SLOT_W = $clog2(SPAN);
  localparam int CS_W   = $clog2(SPAN * 255 + 1);
  localparam int WS_W   = $clog2(SPAN * SPAN * 255 + 1);
  localparam int PX_W   = 3 * rbm_pkg::CH_W;
  localparam int CH_W   = rbm_pkg::CH_W;

  logic                 en;
  logic                 accept;
  logic [COL_W-1:0]     col;
  logic [SLOT_W-1:0]    slot;
  logic [COL_W-1:0]     ocol;
  logic [SLOT_W-1:0]    oslot;
  rbm_pkg::step_flags_t flags;

  logic                 s1_valid;
  logic [PX_W-1:0]      s1_pix;
  rbm_pkg::step_flags_t s1_flags;
  logic [COL_W-1:0]     s1_col;
  logic [SLOT_W-1:0]    s1_slot;
  logic                 fwd;
  logic [3*CS_W-1:0]    fwd_data;
  logic                 s1_we;

  logic [PX_W-1:0]      old_pix;
  logic [PX_W-1:0]      pass_pix;
  logic [3*CS_W-1:0]    cs_mem;
  logic [3*CS_W-1:0]    cs_new;
  logic [3*WS_W-1:0]    win_sum;

  logic                 s2_valid;
  logic                 s2_filter;
  logic                 s2_last;
  logic [PX_W-1:0]      s2_pass;
  logic [PX_W-1:0]      mean_pix;

  assign en          = !result_valid || !result_stall;
  assign pixel_stall = !en;
  assign accept      = pixel_valid && en;
  assign s1_we       = en && s1_valid && s1_flags.write_en;

  rbm_seq #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (write_enable),
    .cfg_index (write_index),
    .cfg_data  (write_data),
    .step      (accept),
    .col       (col),
    .slot      (slot),
    .ocol      (ocol),
    .oslot     (oslot),
    .flags     (flags)
  );

  // two copies of the line store: one read for the row leaving the column
  // sum, one for the pass-through pixel
  rbm_ram #(.WIDTH(PX_W), .DEPTH(SPAN << COL_W)) u_line_old (
    .clk   (clk),
    .we    (s1_we),
    .waddr ({s1_slot, s1_col}),
    .wdata (s1_pix),
    .re    (en),
    .raddr ({slot, col}),
    .rdata (old_pix)
  );

  rbm_ram #(.WIDTH(PX_W), .DEPTH(SPAN << COL_W)) u_line_pass (
    .clk   (clk),
    .we    (s1_we),
    .waddr ({s1_slot, s1_col}),
    .wdata (s1_pix),
    .re    (en),
    .raddr ({oslot, ocol}),
    .rdata (pass_pix)
  );

  rbm_ram #(.WIDTH(3 * CS_W), .DEPTH(MAX_WIDTH)) u_col_sums (
    .clk   (clk),
    .we    (s1_we),
    .waddr (s1_col),
    .wdata (cs_new),
    .re    (en),
    .raddr (col),
    .rdata (cs_mem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else if (en) begin
      s1_valid <= accept;
      fwd      <= accept && s1_we && (col == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pix   <= pixel.kind ? '0 : {pixel.red_in, pixel.green_in, pixel.blue_in};
      s1_flags <= flags;
      s1_col   <= col;
      s1_slot  <= slot;
      fwd_data <= cs_new;
    end
  end

  rbm_accum #(.RADIUS(RADIUS)) u_accum (
    .clk      (clk),
    .rst      (rst),
    .shift    (en && s1_valid),
    .flags    (s1_flags),
    .pix      (s1_pix),
    .old_pix  (old_pix),
    .cs_mem   (cs_mem),
    .fwd      (fwd),
    .fwd_data (fwd_data),
    .cs_new   (cs_new),
    .win_sum  (win_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid && s1_flags.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_filter <= s1_flags.filter;
      s2_last   <= s1_flags.last;
      s2_pass   <= pass_pix;
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_mean
    rbm_mean #(.RADIUS(RADIUS)) u_mean (
      .sum  (win_sum[WS_W*ch +: WS_W]),
      .mean (mean_pix[CH_W*ch +: CH_W])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      {result.red_out, result.green_out, result.blue_out} <= s2_filter ? mean_pix : s2_pass;
      result.frame_end <= s2_last;
    end
  end

  // forwarded column sum only ever stands beside a live beat
  a_fwd_live: assert property (@(posedge clk) disable iff (rst) fwd |-> s1_valid)
    else $error("column sum forward without a beat in stage one");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(s1_valid) && $stable(s2_valid))
    else $error("pipeline moved while the output was stalled");

  // the frame's last pixel is a corner, never a window mean
  a_last_pass: assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_last |-> !s2_filter)
    else $error("frame end flagged on a filtered pixel");

  a_end_beat: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_end && !result_stall |=> !s2_valid || !s2_last)
    else $error("two frame ends back to back");

endmodule

### bench/testbench.sv
// Self-checking bench for rgb_box_mean_filter_core: raster frames of random size and content.
// Depends on rbm_pkg and the design files; a scoreboard class predicts each result beat.
`timescale 1ns / 1ps

module testbench;

  localparam int RADIUS    = 5;
  localparam int MAX_WIDTH = 2048;
  localparam int SPAN      = 2 * RADIUS + 1;
  localparam int AREA      = SPAN * SPAN;
  localparam int STALL_LIMIT = 20000;

  class mean_scoreboard;
    logic [23:0]  lines [SPAN*MAX_WIDTH];
    int unsigned  width_reg, height_reg;
    int unsigned  row_pos, col_pos, out_cnt;
    rbm_pkg::result_t pending[$];
    int           errors, checked;

    function new();
      foreach (lines[i]) lines[i] = '0;
      width_reg  = rbm_pkg::FRAME_WIDTH_RESET;
      height_reg = rbm_pkg::FRAME_HEIGHT_RESET;
      row_pos = 0; col_pos = 0; out_cnt = 0;
      errors = 0; checked = 0;
    endfunction

    function int unsigned eff_w();
      int unsigned w;
      w = width_reg & 32'hFFF;
      if (w == 0) w = 1;
      if (w > MAX_WIDTH) w = MAX_WIDTH;
      return w;
    endfunction

    function int unsigned eff_h();
      int unsigned h;
      h = height_reg & 32'h1FFF;
      if (h == 0) h = 1;
      if (h > rbm_pkg::MAX_HEIGHT) h = rbm_pkg::MAX_HEIGHT;
      return h;
    endfunction

    function logic [23:0] at(int unsigned r, int unsigned c);
      return lines[(r % SPAN) * MAX_WIDTH + (c % MAX_WIDTH)];
    endfunction

    function void set_reg(rbm_pkg::cfg_reg_t idx, logic [rbm_pkg::CFG_DATA_W-1:0] v);
      if (idx == rbm_pkg::REG_FRAME_WIDTH) width_reg = v[rbm_pkg::FW_W-1:0];
      else height_reg = v[rbm_pkg::FH_W-1:0];
      row_pos = 0; col_pos = 0; out_cnt = 0;
    endfunction

    function void note_pixel(rbm_pkg::pixel_t p);
      int unsigned w, h, total, lag, pos, orow, ocol, sr, sg, sb;
      logic [23:0] px;
      rbm_pkg::result_t r;
      w = eff_w(); h = eff_h();
      total = w * h;
      lag = RADIUS * w + RADIUS;
      pos = row_pos * w + col_pos;
      if (pos < total)
        lines[(row_pos % SPAN) * MAX_WIDTH + (col_pos % MAX_WIDTH)] =
          p.kind ? 24'h0 : {p.red_in, p.green_in, p.blue_in};
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (pos >= lag && out_cnt < total) begin
        orow = out_cnt / w;
        ocol = out_cnt % w;
        if (orow >= RADIUS && ocol >= RADIUS && w - ocol > RADIUS && h - orow > RADIUS) begin
          sr = 0; sg = 0; sb = 0;
          for (int i = orow - RADIUS; i <= orow + RADIUS; i++)
            for (int j = ocol - RADIUS; j <= ocol + RADIUS; j++) begin
              px = at(i, j);
              sr += px[23:16]; sg += px[15:8]; sb += px[7:0];
            end
          px = {8'(sr / AREA), 8'(sg / AREA), 8'(sb / AREA)};
        end else begin
          px = at(orow, ocol);
        end
        out_cnt++;
        r.red_out = px[23:16]; r.green_out = px[15:8]; r.blue_out = px[7:0];
        r.frame_end = (out_cnt >= total);
        pending.push_back(r);
        if (r.frame_end) begin
          row_pos = 0; col_pos = 0; out_cnt = 0;
        end
      end
    endfunction

    function void check_result(rbm_pkg::result_t got);
      rbm_pkg::result_t exp_r;
      if (pending.size() == 0) begin
        $error("result beat with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.red_out !== exp_r.red_out) begin
        $error("red_out expected %0d got %0d", exp_r.red_out, got.red_out); errors++;
      end
      if (got.green_out !== exp_r.green_out) begin
        $error("green_out expected %0d got %0d", exp_r.green_out, got.green_out); errors++;
      end
      if (got.blue_out !== exp_r.blue_out) begin
        $error("blue_out expected %0d got %0d", exp_r.blue_out, got.blue_out); errors++;
      end
      if (got.frame_end !== exp_r.frame_end) begin
        $error("frame_end expected %0b got %0b", exp_r.frame_end, got.frame_end); errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  rbm_pkg::pixel_t  pixel = '0;
  logic    pixel_valid = 1'b0;
  logic    pixel_stall;
  rbm_pkg::result_t result;
  logic    result_valid;
  logic    result_stall = 1'b0;
  logic    write_enable = 1'b0;
  rbm_pkg::cfg_reg_t write_index = rbm_pkg::REG_FRAME_WIDTH;
  logic [rbm_pkg::CFG_DATA_W-1:0] write_data = '0;

  mean_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int beats_in = 0;
  int quiet = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  rgb_box_mean_filter_core #(.RADIUS(RADIUS), .MAX_WIDTH(MAX_WIDTH)) DUT (
    .clk(clk), .rst(rst),
    .pixel(pixel), .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .result(result), .result_valid(result_valid), .result_stall(result_stall),
    .write_enable(write_enable), .write_index(write_index), .write_data(write_data)
  );

  always @(posedge clk) begin
    if (!rst) result_stall <= ($urandom_range(99) < stall_pct);
  end

  // monitor and watchdog; reads see pre-edge values
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) sb.check_result(result);
      if (pixel_valid && !pixel_stall) begin
        sb.note_pixel(pixel);
        beats_in++;
      end
      if ((result_valid && !result_stall) || (pixel_valid && !pixel_stall) || write_enable)
        quiet = 0;
      else
        quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic send(rbm_pkg::pixel_t p);
    while ($urandom_range(99) < idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
  endtask

  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // a trailing flush may still be in the pipe
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(rbm_pkg::cfg_reg_t idx, logic [rbm_pkg::CFG_DATA_W-1:0] v);
    write_enable <= 1'b1;
    write_index <= idx;
    write_data <= v;
    sb.set_reg(idx, v);
    @(posedge clk);
    write_enable <= 1'b0;
  endtask

  // content: 0 random, 1 all ones, 2 all zeros; noise mixes in stray flush/real beats
  task automatic run_frame(int content, bit noise);
    int unsigned w, total, lag;
    rbm_pkg::pixel_t p;
    w = sb.eff_w();
    total = w * sb.eff_h();
    lag = RADIUS * w + RADIUS;
    for (int unsigned k = 0; k < total + lag; k++) begin
      p.red_in = 8'($urandom); p.green_in = 8'($urandom); p.blue_in = 8'($urandom);
      if (content == 1) {p.red_in, p.green_in, p.blue_in} = '1;
      if (content == 2) {p.red_in, p.green_in, p.blue_in} = '0;
      p.kind = (k >= total);
      if (noise && $urandom_range(9) == 0) p.kind = ~p.kind;
      send(p);
    end
  endtask

  initial begin
    rbm_pkg::pixel_t p;
    int unsigned w, h;
    int phase;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero registers act as a 1x1 frame
    write_reg(rbm_pkg::REG_FRAME_WIDTH, '0);
    write_reg(rbm_pkg::REG_FRAME_HEIGHT, '0);
    p = '{kind: 1'b0, red_in: 8'hFF, green_in: 8'h00, blue_in: 8'hA5};
    send(p);
    for (int k = 0; k < 10; k++) begin
      p.kind = k[0];
      send(p);
    end
    // flush inside frame stores black, then a stray real beat past the frame
    p.kind = 1'b1;
    send(p);
    p.kind = 1'b0;
    for (int k = 0; k < 10; k++) send(p);
    drain();

    phase = 0;
    while (beats_in < 1200 || phase < 4) begin
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 62; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 62; end
        default: begin idle_pct = 9; stall_pct = 9; end
      endcase
      if (phase % 2 == 0) begin
        // big enough for full windows
        w = $urandom_range(11, 16);
        h = $urandom_range(11, 14);
      end else begin
        w = $urandom_range(0, 12);
        h = $urandom_range(0, 12);
      end
      write_reg(rbm_pkg::REG_FRAME_WIDTH, rbm_pkg::CFG_DATA_W'(w));
      write_reg(rbm_pkg::REG_FRAME_HEIGHT, rbm_pkg::CFG_DATA_W'(h));
      for (int f = 0; f < 2; f++)
        run_frame((phase % 4 == 2) ? f + 1 : 0, $urandom_range(3) == 0);
      drain();
      phase++;
    end

    stall_pct = 0;
    repeat (20) @(posedge clk);
    $display("covered %0d input beats and %0d result beats over %0d frame settings",
             beats_in, sb.checked, phase + 1);
    $display("including zero-size registers, frames below and above the window size,");
    $display("saturated and black content, stray flush and real beats, all stall mixes");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      if (sb.pending.size() != 0) $error("%0d result beats never arrived", sb.pending.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
